// ===== hw/rtl/equirect_point_binning_core_assert.svh =====
// Assertion macros shared by the RTL files.
`ifndef EQUIRECT_POINT_BINNING_CORE_ASSERT_SVH
`define EQUIRECT_POINT_BINNING_CORE_ASSERT_SVH

// Flag a condition that must never hold at a clock edge outside reset.
`define EPB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

// Flag an antecedent that is not met by its consequent in the same cycle.
`define EPB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// ===== hw/rtl/epb_pkg.sv =====
package epb_pkg;

	// Fixed-point format of the coordinate fields
	localparam int FRAC_BITS = 16;
	localparam int LAT_LIM   = 90 * (1 << FRAC_BITS);
	localparam int LON_LIM   = 180 * (1 << FRAC_BITS);

	// 360 = 45 * 2^3 and 180 = 45 * 2^2: shift off the power of two, then divide by 45
	localparam int X_SHIFT   = FRAC_BITS + 3;
	localparam int Y_SHIFT   = FRAC_BITS + 2;
	localparam int DIV_IN_W  = 18;
	// floor(x / 45) = (x * ceil(2^24 / 45)) >> 24, exact for x < 2^18
	localparam int                  DIV45_SHIFT = 24;
	localparam logic [18:0]         DIV45_MULT  = 19'd372828;

	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int ADDR_W     = 24;
	localparam int LIN_W      = 26;
	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = 3;
	localparam int QCNT_W     = 4;

	localparam logic [DIM_W-1:0] DIM_MAX      = 13'd4096;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd2560;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1440;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_READ     = 2'd1,
		OP_READ_CLR = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_OFF_GLOBE   = 2'd1,
		ST_OUT_OF_GRID = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_READ,
		CMD_READ_CLR,
		CMD_REPORT
	} cmd_e;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_WAIT
	} back_state_e;

	typedef struct packed {
		cmd_e               cmd;
		status_e            status;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [ADDR_W-1:0]  addr;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_status_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = 13'd1;
		else if (v > DIM_MAX) r = DIM_MAX;
		else r = v;
		return r;
	endfunction

endpackage

// ===== hw/rtl/epb_queue.sv =====
`include "equirect_point_binning_core_assert.svh"

module epb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  epb_pkg::entry_t wdata,
	input  logic            pop,
	output epb_pkg::entry_t head,
	output logic            empty,
	output logic            full
);

	epb_pkg::entry_t                    mem_q [epb_pkg::QDEPTH];
	logic [epb_pkg::QPTR_W-1:0]         wr_q;
	logic [epb_pkg::QPTR_W-1:0]         rd_q;
	logic [epb_pkg::QCNT_W-1:0]         cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == epb_pkg::QCNT_W'(epb_pkg::QDEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	`EPB_ASSERT_NEVER(a_q_overflow, clk, arst_n, push && full)
	`EPB_ASSERT_NEVER(a_q_underflow, clk, arst_n, pop && empty)

endmodule

// ===== hw/rtl/epb_front.sv =====
`include "equirect_point_binning_core_assert.svh"

module epb_front #(
	parameter int MAX_BINS = 4194304
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic signed [23:0]            latitude,
	input  logic signed [24:0]            longitude,
	input  logic [21:0]                   bin_index,
	input  logic [epb_pkg::DIM_W-1:0]     width,
	input  logic [epb_pkg::DIM_W-1:0]     height,
	input  epb_pkg::bk_status_t           bk_st,
	output logic                          push,
	output epb_pkg::entry_t               entry
);

	localparam int LW = epb_pkg::LIN_W;
	localparam int CW = epb_pkg::COORD_W;
	localparam int DW = epb_pkg::DIM_W;
	localparam int QW = epb_pkg::DIV_IN_W;
	localparam logic signed [LW-1:0] LAT_LIM_W = LW'(epb_pkg::LAT_LIM);
	localparam logic signed [LW-1:0] LON_LIM_W = LW'(epb_pkg::LON_LIM);
	localparam logic [LW-1:0]        BINS_W    = LW'(MAX_BINS);

	logic                           accept;
	logic [epb_pkg::QCNT_W-1:0]     occ_q;

	// stage 1: captured request
	logic                   v_s1;
	logic [1:0]             op_s1;
	logic signed [23:0]     lat_s1;
	logic signed [24:0]     lon_s1;
	logic [21:0]            idx_s1;
	// stage 2: scaled numerators
	logic                   v_s2, off_s2;
	logic [1:0]             op_s2;
	logic [21:0]            idx_s2;
	logic [37:0]            px_s2;
	logic [36:0]            py_s2;
	logic [LW-1:0]          cells_s2;
	// stage 3: reciprocal products
	logic                   v_s3, off_s3, oor_s3;
	logic [1:0]             op_s3;
	logic [21:0]            idx_s3;
	logic [36:0]            qx_s3, qy_s3;
	// stage 4: clamped coordinates
	logic                   v_s4, off_s4, oor_s4;
	logic [1:0]             op_s4;
	logic [21:0]            idx_s4;
	logic [CW-1:0]          col_s4, row_s4;
	// stage 5: linear address
	logic                   v_s5, off_s5, oor_s5;
	logic [1:0]             op_s5;
	logic [21:0]            idx_s5;
	logic [CW-1:0]          col_s5, row_s5;
	logic [LW-1:0]          addr_s5;

	logic signed [LW-1:0]   lat_w, lon_w, ux, uy;
	logic                   off_c;
	logic [DW-1:0]          colq_c, rowq_c;

	assign accept = start && !busy;
	assign busy   = bk_st.clearing || (occ_q == epb_pkg::QCNT_W'(epb_pkg::QDEPTH));

	// outstanding requests: accepted and not yet taken by the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && !bk_st.pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (bk_st.pop && !accept) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	always_comb begin
		lat_w = LW'(lat_s1);
		lon_w = LW'(lon_s1);
		off_c = (lat_w < -LAT_LIM_W) || (lat_w > LAT_LIM_W) ||
			(lon_w < -LON_LIM_W) || (lon_w > LON_LIM_W);
		ux    = lon_w + LON_LIM_W;
		uy    = LAT_LIM_W - lat_w;
	end

	always_comb begin
		colq_c = qx_s3[epb_pkg::DIV45_SHIFT +: DW];
		rowq_c = qy_s3[epb_pkg::DIV45_SHIFT +: DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= operation;
			lat_s1 <= latitude;
			lon_s1 <= longitude;
			idx_s1 <= bin_index;
		end
		op_s2    <= op_s1;
		idx_s2   <= idx_s1;
		off_s2   <= off_c;
		px_s2    <= 38'(ux[24:0]) * 38'(width);
		py_s2    <= 37'(uy[23:0]) * 37'(height);
		cells_s2 <= LW'(width) * LW'(height);

		op_s3  <= op_s2;
		idx_s3 <= idx_s2;
		off_s3 <= off_s2;
		oor_s3 <= (LW'(idx_s2) >= cells_s2) || (LW'(idx_s2) >= BINS_W);
		qx_s3  <= 37'(px_s2[epb_pkg::X_SHIFT +: QW]) * 37'(epb_pkg::DIV45_MULT);
		qy_s3  <= 37'(py_s2[epb_pkg::Y_SHIFT +: QW]) * 37'(epb_pkg::DIV45_MULT);

		// clamp the east edge and the south pole onto the last column or row
		op_s4  <= op_s3;
		idx_s4 <= idx_s3;
		off_s4 <= off_s3;
		oor_s4 <= oor_s3;
		col_s4 <= (colq_c >= width) ? CW'(width - 1'b1) : CW'(colq_c);
		row_s4 <= (rowq_c >= height) ? CW'(height - 1'b1) : CW'(rowq_c);

		op_s5   <= op_s4;
		idx_s5  <= idx_s4;
		off_s5  <= off_s4;
		oor_s5  <= oor_s4;
		col_s5  <= col_s4;
		row_s5  <= row_s4;
		addr_s5 <= LW'(row_s4) * LW'(width) + LW'(col_s4);
	end

	// classify into a back-end command
	always_comb begin
		entry.cmd    = epb_pkg::CMD_REPORT;
		entry.status = epb_pkg::ST_OK;
		entry.col    = '0;
		entry.row    = '0;
		entry.addr   = '0;
		if (op_s5 == epb_pkg::OP_ADD) begin
			if (off_s5) begin
				entry.status = epb_pkg::ST_OFF_GLOBE;
			end else if (addr_s5 >= BINS_W) begin
				entry.status = epb_pkg::ST_OUT_OF_GRID;
				entry.col    = col_s5;
				entry.row    = row_s5;
			end else begin
				entry.cmd  = epb_pkg::CMD_ADD;
				entry.col  = col_s5;
				entry.row  = row_s5;
				entry.addr = addr_s5[epb_pkg::ADDR_W-1:0];
			end
		end else if (oor_s5) begin
			entry.status = epb_pkg::ST_OUT_OF_GRID;
		end else begin
			entry.cmd  = (op_s5 == epb_pkg::OP_READ_CLR) ? epb_pkg::CMD_READ_CLR
				: epb_pkg::CMD_READ;
			entry.addr = epb_pkg::ADDR_W'(idx_s5);
		end
	end

	assign push = v_s5;

	`EPB_ASSERT_IMPLY(a_push_counted, clk, arst_n, push, occ_q != '0)

endmodule

// ===== hw/rtl/epb_back.sv =====
`include "equirect_point_binning_core_assert.svh"

module epb_back #(
	parameter int MAX_BINS   = 4194304,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  epb_pkg::entry_t               head,
	input  logic                          empty,
	output epb_pkg::bk_status_t           bk_st,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [epb_pkg::COORD_W-1:0]   column,
	output logic [epb_pkg::COORD_W-1:0]   row,
	output logic [31:0]                   bin_count
);

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CB = COUNT_BITS;

	epb_pkg::back_state_e           state_q, state_n;
	logic [AW-1:0]                  clr_q;
	logic                           clr_last;
	epb_pkg::entry_t                cur_q;
	logic [CB-1:0]                  mem [MAX_BINS];
	logic [CB-1:0]                  rdata_q;
	logic [CB-1:0]                  cnt_inc;

	logic                           pop, mem_re, mem_we, emit;
	logic [AW-1:0]                  mem_waddr;
	logic [CB-1:0]                  mem_wdata, res_cnt;
	epb_pkg::status_e               res_st;
	logic [epb_pkg::COORD_W-1:0]    res_col, res_row;

	logic                           done_q;
	epb_pkg::status_e               status_q;
	logic [epb_pkg::COORD_W-1:0]    column_q, row_q;
	logic [CB-1:0]                  count_q;

	assign clr_last = (clr_q == AW'(MAX_BINS - 1));
	assign cnt_inc  = (rdata_q == {CB{1'b1}}) ? rdata_q : rdata_q + CB'(1);

	always_comb begin
		state_n = state_q;
		case (state_q)
			epb_pkg::BK_CLEAR: begin
				if (clr_last) state_n = epb_pkg::BK_IDLE;
			end
			epb_pkg::BK_IDLE: begin
				if (!empty && head.cmd != epb_pkg::CMD_REPORT) state_n = epb_pkg::BK_WAIT;
			end
			epb_pkg::BK_WAIT: begin
				state_n = epb_pkg::BK_IDLE;
			end
			default: begin
				state_n = epb_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_q.addr[AW-1:0];
		mem_wdata = '0;
		emit      = 1'b0;
		res_st    = epb_pkg::ST_OK;
		res_col   = '0;
		res_row   = '0;
		res_cnt   = '0;
		case (state_q)
			epb_pkg::BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			epb_pkg::BK_IDLE: begin
				pop = !empty;
				if (!empty && head.cmd == epb_pkg::CMD_REPORT) begin
					emit    = 1'b1;
					res_st  = head.status;
					res_col = head.col;
					res_row = head.row;
				end else begin
					mem_re = !empty;
				end
			end
			epb_pkg::BK_WAIT: begin
				emit    = 1'b1;
				res_col = cur_q.col;
				res_row = cur_q.row;
				res_cnt = (cur_q.cmd == epb_pkg::CMD_ADD) ? cnt_inc : rdata_q;
				mem_we  = (cur_q.cmd == epb_pkg::CMD_ADD) ||
					(cur_q.cmd == epb_pkg::CMD_READ_CLR);
				mem_wdata = (cur_q.cmd == epb_pkg::CMD_ADD) ? cnt_inc : '0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epb_pkg::BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == epb_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (emit) begin
			status_q <= res_st;
			column_q <= res_col;
			row_q    <= res_row;
			count_q  <= res_cnt;
		end
	end

	// single-port style bin store: read registered, write in the following cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[head.addr[AW-1:0]];
	end

	assign bk_st.pop      = pop;
	assign bk_st.clearing = (state_q == epb_pkg::BK_CLEAR);

	assign done      = done_q;
	assign status    = status_q;
	assign column    = column_q;
	assign row       = row_q;
	assign bin_count = 32'(count_q);

	`EPB_ASSERT_NEVER(a_no_result_in_clear, clk, arst_n, bk_st.clearing && done_q)

endmodule

// ===== hw/rtl/equirect_point_binning_core.sv =====
// Equirectangular point binning: a 2D histogram of geographic points.
// Request channel: drive operation, latitude, longitude and bin_index with
// start; a request is taken at a rising edge where start is high and busy
// is low. Operation add maps the point to a column and a row (row 0 at
// north) and bumps a saturating counter; read and read-clear return a bin.
// Result channel: done is high for exactly one cycle with status, column,
// row and bin_count; the receiver cannot hold results off, so none wait.
// The back end reads a bin of the single bin memory and then writes it back,
// so it takes no new store request until that write is done; requests that
// become reports (off-globe points, out-of-grid bins) need no such wait.
// Up to 8 requests may be outstanding; busy rises when all 8 are taken.
// Reset: the grid registers return to 2560 x 1440 and the back end sweeps
// the bin store to zero, one bin a cycle; busy stays high through the sweep.
// Write the grid registers only while no request is in flight.
module equirect_point_binning_core #(
	parameter int MAX_BINS   = 4194304,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic signed [23:0]  latitude,
	input  logic signed [24:0]  longitude,
	input  logic [21:0]         bin_index,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [12:0]         cfg_wdata,
	output logic                done,
	output logic [1:0]          status,
	output logic [11:0]         column,
	output logic [11:0]         row,
	output logic [31:0]         bin_count
);

	logic [epb_pkg::DIM_W-1:0]  width_q;
	logic [epb_pkg::DIM_W-1:0]  height_q;

	epb_pkg::bk_status_t        bk_st;
	epb_pkg::entry_t            push_entry;
	epb_pkg::entry_t            head;
	logic                       push;
	logic                       empty;
	logic                       full;

	// Grid size registers; clamp each write into the range 1..4096
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= epb_pkg::WIDTH_RESET;
			height_q <= epb_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				epb_pkg::CFG_IMAGE_WIDTH:  width_q  <= epb_pkg::clamp_dim(cfg_wdata);
				epb_pkg::CFG_IMAGE_HEIGHT: height_q <= epb_pkg::clamp_dim(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Front end: take requests, project points, classify into commands
	epb_front #(
		.MAX_BINS (MAX_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.latitude  (latitude),
		.longitude (longitude),
		.bin_index (bin_index),
		.width     (width_q),
		.height    (height_q),
		.bk_st     (bk_st),
		.push      (push),
		.entry     (push_entry)
	);

	// Command queue; the front end's credit count keeps it from overflowing
	epb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (bk_st.pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	// Back end: clear sweep, then read-modify-write of the bin store or a report
	epb_back #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.bk_st     (bk_st),
		.done      (done),
		.status    (status),
		.column    (column),
		.row       (row),
		.bin_count (bin_count)
	);

	// busy must hold throughout the clearing sweep
	`EPB_ASSERT_IMPLY(a_busy_in_clear, clk, arst_n, bk_st.clearing, busy)
	// a full queue means every credit is taken
	`EPB_ASSERT_IMPLY(a_busy_when_full, clk, arst_n, full, busy)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// Bin store depth of the instance, and the spare operation code that reads without clearing
	localparam int         STORE_BINS    = 4194304;
	localparam logic [1:0] OP_SPARE_READ = 2'd3;
	// Cycles to let pass once nothing is owed
	localparam int         SETTLE_CYCLES = 24;
	// The limit leaves room for the reset sweep of the whole store
	localparam longint     CYCLE_LIMIT   = 64'd4194304 + 64'd600000;
	localparam int         REPORT_MAX    = 10;
	localparam int         RECENT_MAX    = 24;
	localparam int         LAT_LIM       = epb_pkg::LAT_LIM;
	localparam int         LON_LIM       = epb_pkg::LON_LIM;

	typedef struct {
		logic [1:0]         op;
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic [21:0]        idx;
		bit                 await_idle;
	} bin_req_t;

	typedef struct {
		epb_pkg::status_e status;
		logic [11:0]      column;
		logic [11:0]      row;
		logic [31:0]      count;
	} tally_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic               busy;
	logic [1:0]         operation = epb_pkg::OP_ADD;
	logic signed [23:0] latitude  = '0;
	logic signed [24:0] longitude = '0;
	logic [21:0]        bin_index = '0;
	logic               cfg_we    = 1'b0;
	logic               cfg_index = epb_pkg::CFG_IMAGE_WIDTH;
	logic [12:0]        cfg_wdata = '0;
	logic               done;
	logic [1:0]         status;
	logic [11:0]        column;
	logic [11:0]        row;
	logic [31:0]        bin_count;

	// Requests waiting for the driver, and tallies owed by the block, oldest first
	bin_req_t    pending_requests [$];
	tally_t      expected_tallies [$];
	// Mirror of the bin store; an entry never touched reads as zero
	logic [31:0] tally_mirror [int];
	int          grid_w = 2560;
	int          grid_h = 1440;
	logic        tallies_owed = 1'b0;
	int          mismatch_count = 0;
	int          accepted_count = 0;
	longint      cycle_count = 0;

	equirect_point_binning_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.latitude  (latitude),
		.longitude (longitude),
		.bin_index (bin_index),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.column    (column),
		.row       (row),
		.bin_count (bin_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// A zero grid dimension counts as one, anything above the largest grid as the largest
	function automatic int grid_dim(input logic [12:0] raw);
		if (raw == '0) return 1;
		if (raw > 13'd4096) return 4096;
		return int'(raw);
	endfunction

	// Equirectangular mapping; returns 0 for a point off the globe
	function automatic bit project_point(input logic signed [23:0] lat,
			input logic signed [24:0] lon, input int w, input int h,
			output int col, output int rw);
		longint la;
		longint lo;
		la = lat;
		lo = lon;
		col = 0;
		rw = 0;
		if (la < -LAT_LIM || la > LAT_LIM || lo < -LON_LIM || lo > LON_LIM) return 1'b0;
		col = int'(((lo + LON_LIM) * w) / (2 * LON_LIM));
		rw  = int'(((LAT_LIM - la) * h) / (2 * LAT_LIM));
		// The south pole and the east edge land one past the grid: pull them back
		if (col >= w) col = w - 1;
		if (rw >= h) rw = h - 1;
		return 1'b1;
	endfunction

	// Apply one request to the mirror and work out the tally the block must return
	function automatic tally_t predict_tally(input logic [1:0] op,
			input logic signed [23:0] lat, input logic signed [24:0] lon,
			input logic [21:0] idx);
		tally_t t;
		int     col;
		int     rw;
		longint addr;
		logic [31:0] c;
		t = '{epb_pkg::ST_OK, '0, '0, '0};
		if (op == epb_pkg::OP_ADD) begin
			if (!project_point(lat, lon, grid_w, grid_h, col, rw)) begin
				t.status = epb_pkg::ST_OFF_GLOBE;
				return t;
			end
			t.column = 12'(col);
			t.row    = 12'(rw);
			addr = longint'(rw) * grid_w + col;
			if (addr >= STORE_BINS) begin
				t.status = epb_pkg::ST_OUT_OF_GRID;
				return t;
			end
			c = tally_mirror.exists(int'(addr)) ? tally_mirror[int'(addr)] : 32'd0;
			if (c != 32'hFFFF_FFFF) c = c + 32'd1;
			tally_mirror[int'(addr)] = c;
			t.count = c;
		end else begin
			addr = longint'(idx);
			if (addr >= longint'(grid_w) * grid_h || addr >= STORE_BINS) begin
				t.status = epb_pkg::ST_OUT_OF_GRID;
				return t;
			end
			c = tally_mirror.exists(int'(addr)) ? tally_mirror[int'(addr)] : 32'd0;
			if (op == epb_pkg::OP_READ_CLR) tally_mirror[int'(addr)] = 32'd0;
			t.count = c;
		end
		return t;
	endfunction

	// Driver: hold a request until it is taken, then advance or idle at random.
	// A request marked await_idle is held back until the block owes nothing.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		bit       taken;
		bit       go;
		bin_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) accepted_count++;
			if (!start || taken) begin
				go = pending_requests.size() != 0;
				if (go && pending_requests[0].await_idle && (start || tallies_owed)) go = 1'b0;
				// No random idling through a long stretch in the middle of the run
				if (go && !(accepted_count >= 500 && accepted_count < 800))
					go = $urandom_range(0, 99) >= 38;
				if (go) begin
					nxt = pending_requests.pop_front();
					operation <= nxt.op;
					latitude  <= nxt.lat;
					longitude <= nxt.lon;
					bin_index <= nxt.idx;
					start     <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on every taken request, check every strobed result
	always @(posedge clk or negedge arst_n) begin : check_tallies
		tally_t want;
		if (!arst_n) begin
			tallies_owed <= 1'b0;
		end else begin
			if (start && !busy)
				expected_tallies.push_back(predict_tally(operation, latitude, longitude, bin_index));
			if (done) begin
				if (expected_tallies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected result: status %0d column %0d row %0d count %0d",
							status, column, row, bin_count);
				end else begin
					want = expected_tallies.pop_front();
					if (status !== want.status || column !== want.column ||
							row !== want.row || bin_count !== want.count) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display({"mismatch: expected status %0d column %0d row %0d ",
								"count %0d, got status %0d column %0d row %0d count %0d"},
								want.status, want.column, want.row, want.count,
								status, column, row, bin_count);
					end
				end
			end
			tallies_owed <= expected_tallies.size() != 0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_request(input logic [1:0] op, input logic signed [23:0] lat,
			input logic signed [24:0] lon, input logic [21:0] idx);
		pending_requests.push_back('{op, lat, lon, idx, 1'b0});
	endtask

	// Wait for the driver to run dry and every tally to come back, then a little more
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_requests.size() != 0 || start || expected_tallies.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_grid(input logic idx, input logic [12:0] raw);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == epb_pkg::CFG_IMAGE_WIDTH) grid_w = grid_dim(raw);
		else grid_h = grid_dim(raw);
	endtask

	task automatic set_grid(input logic [12:0] w_raw, input logic [12:0] h_raw);
		write_grid(epb_pkg::CFG_IMAGE_WIDTH, w_raw);
		write_grid(epb_pkg::CFG_IMAGE_HEIGHT, h_raw);
		@(negedge clk);
	endtask

	// Mostly points on the globe with repeats so that bins fill up, reads aimed at
	// bins that were hit, and a share of edges, off-globe noise and stray indexes
	task automatic queue_random_requests(input int n);
		logic signed [23:0] recent_lat [$];
		logic signed [24:0] recent_lon [$];
		bin_req_t r;
		int       pick;
		int       col;
		int       rw;
		int       k;
		longint   cells;
		longint   addr;
		cells = longint'(grid_w) * grid_h;
		for (int i = 0; i < n; i++) begin
			r.lat = 24'($urandom);
			r.lon = 25'($urandom);
			r.idx = 22'($urandom);
			r.await_idle = (i == n / 2);
			pick = $urandom_range(0, 99);
			if (pick < 55) r.op = epb_pkg::OP_ADD;
			else if (pick < 75) r.op = epb_pkg::OP_READ;
			else if (pick < 93) r.op = epb_pkg::OP_READ_CLR;
			else r.op = OP_SPARE_READ;
			if (r.op == epb_pkg::OP_ADD) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					r.lat = 24'(int'($urandom_range(0, 2 * LAT_LIM)) - LAT_LIM);
					r.lon = 25'(int'($urandom_range(0, 2 * LON_LIM)) - LON_LIM);
				end else if (pick < 72 && recent_lat.size() != 0) begin
					k = $urandom_range(0, recent_lat.size() - 1);
					r.lat = recent_lat[k];
					r.lon = recent_lon[k];
				end else if (pick < 85) begin
					case ($urandom_range(0, 5))
						0: r.lat = 24'(LAT_LIM);
						1: r.lat = 24'(-LAT_LIM);
						2: r.lat = 24'(LAT_LIM + 1);
						3: r.lat = 24'(-LAT_LIM - 1);
						4: r.lat = '0;
						default: r.lat = -24'sd1;
					endcase
					case ($urandom_range(0, 5))
						0: r.lon = 25'(LON_LIM);
						1: r.lon = 25'(-LON_LIM);
						2: r.lon = 25'(LON_LIM + 1);
						3: r.lon = 25'(-LON_LIM - 1);
						4: r.lon = '0;
						default: r.lon = -25'sd1;
					endcase
				end
				// anything else keeps the raw noise, mostly off the globe
				recent_lat.push_back(r.lat);
				recent_lon.push_back(r.lon);
				if (recent_lat.size() > RECENT_MAX) begin
					void'(recent_lat.pop_front());
					void'(recent_lon.pop_front());
				end
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60 && recent_lat.size() != 0) begin
					k = $urandom_range(0, recent_lat.size() - 1);
					if (project_point(recent_lat[k], recent_lon[k], grid_w, grid_h, col, rw)) begin
						addr = longint'(rw) * grid_w + col;
						if (addr < STORE_BINS) r.idx = 22'(addr);
					end
				end else if (pick < 85) begin
					addr = (cells < STORE_BINS) ? cells : STORE_BINS;
					r.idx = 22'($urandom_range(0, int'(addr) - 1));
				end else if (pick < 92 && cells < STORE_BINS) begin
					r.idx = 22'(cells);
				end
			end
			pending_requests.push_back(r);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests on the reset grid of 2560 x 1440
		push_request(epb_pkg::OP_ADD, 24'(LAT_LIM), 25'(-LON_LIM), '0);
		push_request(epb_pkg::OP_ADD, 24'(LAT_LIM), 25'(-LON_LIM), '0);
		push_request(epb_pkg::OP_ADD, 24'(-LAT_LIM), 25'(LON_LIM), '0);
		push_request(epb_pkg::OP_ADD, '0, '0, '0);
		push_request(epb_pkg::OP_ADD, -24'sd1, -25'sd1, '0);
		push_request(epb_pkg::OP_ADD, 24'(LAT_LIM), 25'(LON_LIM), '0);
		push_request(epb_pkg::OP_ADD, 24'(LAT_LIM + 1), '0, '0);
		push_request(epb_pkg::OP_ADD, 24'(-LAT_LIM - 1), '0, '0);
		push_request(epb_pkg::OP_ADD, '0, 25'(LON_LIM + 1), '0);
		push_request(epb_pkg::OP_ADD, '0, 25'(-LON_LIM - 1), '0);
		push_request(epb_pkg::OP_ADD, 24'h7F_FFFF, '0, 22'h3F_FFFF);
		push_request(epb_pkg::OP_ADD, 24'h80_0000, '0, '0);
		push_request(epb_pkg::OP_ADD, '0, 25'h0FF_FFFF, '0);
		push_request(epb_pkg::OP_ADD, '0, 25'h100_0000, '0);
		push_request(epb_pkg::OP_READ, '0, '0, '0);
		push_request(OP_SPARE_READ, '0, '0, '0);
		push_request(epb_pkg::OP_READ_CLR, '0, '0, '0);
		push_request(epb_pkg::OP_READ, '0, '0, '0);
		// Last bin of the grid, where the south-east corner was clamped
		push_request(epb_pkg::OP_READ_CLR, '0, '0, 22'd3686399);
		push_request(epb_pkg::OP_READ, '0, '0, 22'd3686399);
		push_request(epb_pkg::OP_READ, '0, '0, 22'd3686400);
		push_request(epb_pkg::OP_READ, 24'h7F_FFFF, 25'h1FF_FFFF, 22'h3F_FFFF);
		push_request(epb_pkg::OP_READ_CLR, '0, '0, 22'h3F_FFFF);
		queue_random_requests(200);
		wait_quiet();

		// One column of 4096 rows, both from clamped register values
		set_grid(13'd0, 13'h1FFF);
		queue_random_requests(150);
		wait_quiet();

		// Largest grid: the southern three quarters lie beyond the store
		set_grid(13'd4096, 13'd4096);
		queue_random_requests(200);
		wait_quiet();

		set_grid(13'd1, 13'd1);
		queue_random_requests(100);
		wait_quiet();

		// Small grids so that bins collect several points each
		repeat (4) begin
			set_grid(13'($urandom_range(1, 48)), 13'($urandom_range(1, 48)));
			queue_random_requests(150);
			wait_quiet();
		end

		set_grid(13'd4097, 13'($urandom_range(0, 8191)));
		queue_random_requests(200);
		wait_quiet();

		set_grid(13'd2560, 13'd1440);
		queue_random_requests(50);
		wait_quiet();

		if (mismatch_count == 0 && expected_tallies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
